### sv/csa_pkg.sv
`default_nettype none
package csa_pkg;
   localparam int MaxSegments = 16;
   localparam int IdxW = $clog2(MaxSegments);
   localparam int CntW = $clog2(MaxSegments + 1);
   localparam int AddrW = 31;
   localparam int OwnerW = 16;

   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_COMPACT = 2'd2;

   localparam logic [1:0] METHOD_FIRST = 2'd0;
   localparam logic [1:0] METHOD_BEST = 2'd1;
   localparam logic [1:0] METHOD_WORST = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NOFIT = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_NOOWNER = 3'd3;
   localparam logic [2:0] ST_BADMETHOD = 3'd4;

   typedef struct packed {
      logic [AddrW-1:0] base;
      logic [AddrW-1:0] size;
      logic [OwnerW-1:0] owner;
   } seg_type;
endpackage
`default_nettype wire

### sv/csa_table.sv
`default_nettype none
// Segment table memory: one write port, one registered read port.
module csa_table (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [csa_pkg::IdxW-1:0] wr_addr,
   input wire csa_pkg::seg_type wr_data,
   input wire logic [csa_pkg::IdxW-1:0] rd_addr,
   output csa_pkg::seg_type rd_data
);
   import csa_pkg::*;
   seg_type mem [MaxSegments];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### sv/contiguous_segment_allocator.sv
`default_nettype none
// Channel   Ports                                 Handshake
// request   req_kind/amount/owner/method           start & !busy
// result    rsp_status/rsp_granted_base            rsp_valid, one cycle
// config    csr_total_size                         csr_we
// A request scans the table one gap at a time (S_SCAN presents the address,
// S_EVAL uses the read data), then shifts entries up one at a time (S_MOVE_RD,
// S_MOVE_WR); release and compact also walk the table one entry at a time. The
// single table read port forces this. Reset empties the table (count to zero).
// The result cannot be stalled; busy stays high until the result cycle ends.
module contiguous_segment_allocator (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_kind,
   input wire logic [30:0] req_amount,
   input wire logic [15:0] req_owner,
   input wire logic [1:0] req_method,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [30:0] rsp_granted_base,
   input wire logic csr_we,
   input wire logic [30:0] csr_total_size
);
   import csa_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_MOVE_RD = 3'd3;
   localparam logic [2:0] S_MOVE_WR = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [AddrW-1:0] total_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [1:0] kind_ff;
   logic [1:0] method_ff;
   logic [AddrW-1:0] amount_ff;
   logic [OwnerW-1:0] owner_ff;
   logic [AddrW:0] prev_end_ff, prev_end_in;
   logic found_ff, found_in;
   logic [CntW-1:0] pick_ff, pick_in;
   logic [AddrW:0] pick_start_ff, pick_start_in;
   logic [AddrW:0] pick_surp_ff, pick_surp_in;
   logic [2:0] status_ff, status_in;
   logic [AddrW-1:0] gbase_ff, gbase_in;
   logic valid_ff, valid_in;
   logic accept;

   logic wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   seg_type wr_data, rd_data;

   csa_table u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign accept = start && !busy;

   // Gap under evaluation: from prev_end_ff to the entry read, or to total_size.
   logic at_top;
   logic [AddrW:0] gap_end, gap_len, surplus;
   logic fits;
   logic [AddrW:0] seg_end;
   always_comb begin
      at_top = (idx_ff == count_ff);
      gap_end = at_top ? {1'b0, total_ff} : {1'b0, rd_data.base};
      gap_len = gap_end - prev_end_ff;
      fits = (gap_end >= prev_end_ff) && (gap_len >= {1'b0, amount_ff});
      surplus = gap_len - {1'b0, amount_ff};
      seg_end = {1'b0, rd_data.base} + {1'b0, rd_data.size};
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      prev_end_in = prev_end_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      pick_start_in = pick_start_ff;
      pick_surp_in = pick_surp_ff;
      status_in = status_ff;
      gbase_in = gbase_ff;
      valid_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = idx_ff[IdxW-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[IdxW-1:0];
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            prev_end_in = '0;
            found_in = 1'b0;
            status_in = ST_OK;
            gbase_in = '0;
            if (accept) begin
               state_in = S_SCAN;
               if (req_kind == KIND_REQUEST) begin
                  if (req_method > METHOD_WORST) begin
                     status_in = ST_BADMETHOD;
                     state_in = S_DONE;
                  end else if (count_ff == CntW'(MaxSegments)) begin
                     status_in = ST_FULL;
                     state_in = S_DONE;
                  end
               end else if (req_kind == KIND_RELEASE) begin
                  status_in = ST_NOOWNER;
               end else if (req_kind != KIND_COMPACT) begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // Read address idx_ff is presented this cycle.
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (kind_ff)
               KIND_REQUEST: begin
                  if (fits && (!found_ff ||
                      (method_ff == METHOD_BEST && surplus < pick_surp_ff) ||
                      (method_ff == METHOD_WORST && surplus > pick_surp_ff))) begin
                     found_in = 1'b1;
                     pick_in = idx_ff;
                     pick_start_in = prev_end_ff;
                     pick_surp_in = surplus;
                  end
                  prev_end_in = seg_end;
                  idx_in = idx_ff + 1'b1;
                  state_in = S_SCAN;
                  if (at_top || (method_ff == METHOD_FIRST && fits)) begin
                     if (!(fits || found_ff)) begin
                        status_in = ST_NOFIT;
                        state_in = S_DONE;
                     end else begin
                        // Shift entries at or above the pick up by one.
                        idx_in = count_ff;
                        state_in = S_MOVE_RD;
                     end
                  end
               end
               KIND_RELEASE: begin
                  if (found_ff) begin
                     // The count has already dropped, so the old top is one higher.
                     if (idx_ff == count_ff + 1'b1) begin
                        state_in = S_DONE;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = IdxW'(idx_ff - 1'b1);
                        idx_in = idx_ff + 1'b1;
                        state_in = S_SCAN;
                     end
                  end else if (at_top) begin
                     state_in = S_DONE;
                  end else begin
                     if (rd_data.owner == owner_ff) begin
                        found_in = 1'b1;
                        status_in = ST_OK;
                        count_in = count_ff - 1'b1;
                     end
                     idx_in = idx_ff + 1'b1;
                     state_in = (rd_data.owner == owner_ff && idx_ff + 1'b1 == count_ff)
                        ? S_DONE : S_SCAN;
                  end
               end
               default: begin
                  // Compact: each entry's base becomes the running end.
                  if (at_top) begin
                     state_in = S_DONE;
                  end else begin
                     wr_en = 1'b1;
                     wr_data.base = prev_end_ff[AddrW-1:0];
                     prev_end_in = prev_end_ff + {1'b0, rd_data.size};
                     idx_in = idx_ff + 1'b1;
                     state_in = S_SCAN;
                  end
               end
            endcase
         end
         S_MOVE_RD: begin
            rd_addr = IdxW'(idx_ff - 1'b1);
            if (idx_ff == pick_ff) begin
               wr_en = 1'b1;
               wr_data.base = pick_start_ff[AddrW-1:0];
               wr_data.size = amount_ff;
               wr_data.owner = owner_ff;
               gbase_in = pick_start_ff[AddrW-1:0];
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_MOVE_WR;
            end
         end
         S_MOVE_WR: begin
            wr_en = 1'b1;
            idx_in = idx_ff - 1'b1;
            state_in = S_MOVE_RD;
         end
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         if (csr_we) begin
            total_ff <= csr_total_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      prev_end_ff <= prev_end_in;
      found_ff <= found_in;
      pick_ff <= pick_in;
      pick_start_ff <= pick_start_in;
      pick_surp_ff <= pick_surp_in;
      status_ff <= status_in;
      gbase_ff <= gbase_in;
      if (state_ff == S_IDLE && accept) begin
         kind_ff <= req_kind;
         method_ff <= req_method;
         amount_ff <= req_amount;
         owner_ff <= req_owner;
      end
   end

   assign busy = (state_ff != S_IDLE) || valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_granted_base = gbase_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxSegments)) else $error("segment count overflow");
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff) else $error("result strobe longer than one cycle");
   a_base_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != ST_OK |-> gbase_ff == '0)
      else $error("granted base on failure");
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import csa_pkg::*;

   localparam int LatencyCycles = 4 * MaxSegments + 16;
   localparam int CycleLimit = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = KIND_REQUEST;
   logic [30:0] req_amount = '0;
   logic [15:0] req_owner = '0;
   logic [1:0] req_method = METHOD_FIRST;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [30:0] rsp_granted_base;
   logic csr_we = 1'b0;
   logic [30:0] csr_total_size = '0;

   contiguous_segment_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_amount(req_amount), .req_owner(req_owner),
      .req_method(req_method), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_granted_base(rsp_granted_base), .csr_we(csr_we),
      .csr_total_size(csr_total_size)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct packed {
      logic [2:0] status;
      logic [30:0] base;
   } grant_type;

   typedef struct {
      logic [1:0] kind;
      logic [30:0] amount;
      logic [15:0] owner;
      logic [1:0] method;
      bit fixed;
      grant_type want;
   } row_type;

   // Shadow copy of the allocator state.
   logic [30:0] mem_size;
   seg_type segs[MaxSegments];
   int unsigned seg_cnt;

   grant_type pending_grants[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned grant_count = 0;
   int unsigned nofit_count = 0;
   int unsigned full_count = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic longint unsigned gap_lo(int unsigned g);
      if (g == 0) return 0;
      return longint'(segs[g-1].base) + longint'(segs[g-1].size);
   endfunction

   function automatic longint unsigned gap_hi(int unsigned g);
      if (g < seg_cnt) return longint'(segs[g].base);
      return longint'(mem_size);
   endfunction

   function automatic grant_type predict_allocation(logic [1:0] kind, logic [30:0] amount,
                                                    logic [15:0] owner, logic [1:0] method);
      grant_type res;
      bit found;
      int unsigned pick;
      longint unsigned best, s, e, sur, nxt;
      res = '{ST_OK, 31'd0};
      found = 0;
      pick = 0;
      best = 0;
      nxt = 0;
      if (kind == KIND_REQUEST) begin
         if (method != METHOD_FIRST && method != METHOD_BEST && method != METHOD_WORST)
            res.status = ST_BADMETHOD;
         else if (seg_cnt >= MaxSegments)
            res.status = ST_FULL;
         else begin
            for (int unsigned g = 0; g <= seg_cnt; g++) begin
               s = gap_lo(g);
               e = gap_hi(g);
               if (e < s || e - s < longint'(amount)) continue;
               sur = e - s - longint'(amount);
               if (!found || (method == METHOD_BEST && sur < best) ||
                   (method == METHOD_WORST && sur > best)) begin
                  found = 1;
                  pick = g;
                  best = sur;
                  if (method == METHOD_FIRST) break;
               end
            end
            if (!found)
               res.status = ST_NOFIT;
            else begin
               s = gap_lo(pick);
               for (int unsigned i = seg_cnt; i > pick; i--) segs[i] = segs[i-1];
               segs[pick] = '{s[30:0], amount, owner};
               seg_cnt++;
               res.base = s[30:0];
            end
         end
      end else if (kind == KIND_RELEASE) begin
         res.status = ST_NOOWNER;
         for (int unsigned i = 0; i < seg_cnt; i++) begin
            if (segs[i].owner == owner) begin
               for (int unsigned j = i; j + 1 < seg_cnt; j++) segs[j] = segs[j+1];
               seg_cnt--;
               res.status = ST_OK;
               break;
            end
         end
      end else if (kind == KIND_COMPACT) begin
         for (int unsigned i = 0; i < seg_cnt; i++) begin
            segs[i].base = nxt[30:0];
            nxt += longint'(segs[i].size);
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0)
            report_mismatch("result with nothing expected");
         else begin
            grant_type w;
            w = pending_grants.pop_front();
            if (rsp_status !== w.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, w.status));
            if (rsp_granted_base !== w.base)
               report_mismatch($sformatf("base %0h, expected %0h", rsp_granted_base, w.base));
            if (w.status == ST_OK) grant_count++;
            if (w.status == ST_NOFIT) nofit_count++;
            if (w.status == ST_FULL) full_count++;
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   bit quiet;

   task automatic send_cmd(row_type r);
      grant_type w;
      if (!quiet)
         while ($urandom_range(99) < 22) @(posedge clock);
      w = predict_allocation(r.kind, r.amount, r.owner, r.method);
      if (r.fixed && w !== r.want)
         report_mismatch("directed row disagrees with prediction");
      req_kind <= r.kind;
      req_amount <= r.amount;
      req_owner <= r.owner;
      req_method <= r.method;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_grants.push_back(w);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_size(logic [30:0] v);
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (LatencyCycles) @(posedge clock);
      csr_total_size <= v;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      mem_size = v;
      @(posedge clock);
   endtask

   function automatic row_type mk(logic [1:0] k, logic [30:0] a, logic [15:0] o,
                                  logic [1:0] m, bit f = 0, logic [2:0] st = ST_OK,
                                  logic [30:0] b = 0);
      row_type r;
      r = '{k, a, o, m, f, '{st, b}};
      return r;
   endfunction

   function automatic row_type random_cmd();
      int unsigned p;
      row_type r;
      p = $urandom_range(99);
      r = mk(KIND_REQUEST, 0, 16'($urandom_range(7)), 2'($urandom_range(2)));
      if (p < 55) begin
         case ($urandom_range(3))
            0: r.amount = 31'($urandom_range(8));
            1: r.amount = 31'($urandom_range(64));
            2: r.amount = 31'($urandom_range(mem_size / 4 + 1));
            default: r.amount = 31'($urandom);
         endcase
      end else if (p < 85) begin
         r.kind = KIND_RELEASE;
      end else if (p < 92) begin
         r.kind = KIND_COMPACT;
      end else if (p < 96) begin
         r.method = 2'd3;
         r.amount = 31'($urandom);
      end else begin
         r.kind = 2'd3;
         r.amount = 31'($urandom);
      end
      if ($urandom_range(9) == 0) r.owner = 16'($urandom);
      return r;
   endfunction

   row_type directed[$];
   logic [30:0] sizes[6];

   initial begin
      seg_cnt = 0;
      mem_size = '0;
      quiet = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero memory after reset: only zero-size requests fit.
      directed = '{
         mk(KIND_REQUEST, 1, 16'h0001, METHOD_FIRST, 1, ST_NOFIT, 0),
         mk(KIND_RELEASE, 0, 16'hFFFF, METHOD_FIRST, 1, ST_NOOWNER, 0),
         mk(KIND_COMPACT, 0, 0, METHOD_FIRST, 1, ST_OK, 0),
         mk(KIND_REQUEST, 0, 16'h0002, 2'd3, 1, ST_BADMETHOD, 0),
         mk(2'd3, 31'h7FFFFFFF, 16'hFFFF, 2'd3, 1, ST_OK, 0),
         mk(KIND_REQUEST, 0, 16'hFFFF, METHOD_WORST, 1, ST_OK, 0),
         mk(KIND_RELEASE, 0, 16'hFFFF, METHOD_FIRST, 1, ST_OK, 0)
      };
      foreach (directed[i]) send_cmd(directed[i]);

      write_size(31'd100);
      directed = '{
         mk(KIND_REQUEST, 10, 16'h0010, METHOD_FIRST, 1, ST_OK, 0),
         mk(KIND_REQUEST, 20, 16'h0011, METHOD_FIRST, 1, ST_OK, 10),
         mk(KIND_REQUEST, 5, 16'h0012, METHOD_FIRST, 1, ST_OK, 30),
         mk(KIND_RELEASE, 0, 16'h0011, METHOD_FIRST),
         mk(KIND_REQUEST, 20, 16'h0013, METHOD_WORST),
         mk(KIND_REQUEST, 7, 16'h0014, METHOD_BEST),
         mk(KIND_REQUEST, 13, 16'h0015, METHOD_BEST),
         mk(KIND_REQUEST, 101, 16'h0016, METHOD_FIRST, 1, ST_NOFIT, 0),
         mk(KIND_COMPACT, 0, 0, METHOD_FIRST),
         mk(KIND_REQUEST, 0, 16'h0017, METHOD_WORST)
      };
      foreach (directed[i]) send_cmd(directed[i]);
      // Fill the table to see the full condition ahead of the gap search.
      while (seg_cnt < MaxSegments) send_cmd(mk(KIND_REQUEST, 0, 16'h00AA, METHOD_FIRST));
      send_cmd(mk(KIND_REQUEST, 0, 16'h00AB, METHOD_FIRST, 1, ST_FULL, 0));
      send_cmd(mk(KIND_REQUEST, 0, 16'h00AB, 2'd3, 1, ST_BADMETHOD, 0));

      // Shrink below the top segment, then grow to the maximum.
      write_size(31'd20);
      send_cmd(mk(KIND_RELEASE, 0, 16'h0010, METHOD_FIRST));
      send_cmd(mk(KIND_REQUEST, 3, 16'h0020, METHOD_WORST));
      write_size(31'h7FFFFFFF);
      send_cmd(mk(KIND_REQUEST, 31'h7FFFFFFF, 16'h0021, METHOD_BEST));

      sizes = '{31'd0, 31'd64, 31'd1000, 31'h7FFFFFFF, 31'd300, 31'($urandom)};
      foreach (sizes[ph]) begin
         write_size(sizes[ph]);
         quiet = (ph == 2);
         repeat (320) send_cmd(random_cmd());
      end
      quiet = 0;

      while (pending_grants.size() != 0) @(posedge clock);
      repeat (LatencyCycles) @(posedge clock);
      $display("Covered %0d grants, %0d no-fit and %0d table-full answers",
               grant_count, nofit_count, full_count);
      $display("over six memory sizes, all placement methods, release and compact.");
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
